[sv/cesd_pkg.sv]
// ----------------------------------------------------------------------------
// cesd_pkg
// Shared types and character codes of the escape sequence decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

    // character codes
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] LET_A     = 8'h61;
    localparam logic [7:0] LET_B     = 8'h62;
    localparam logic [7:0] LET_F     = 8'h66;
    localparam logic [7:0] LET_N     = 8'h6E;
    localparam logic [7:0] LET_R     = 8'h72;
    localparam logic [7:0] LET_T     = 8'h74;
    localparam logic [7:0] LET_V     = 8'h76;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // decoded results of one input byte: one or two words
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
    } cesd_entry_t;

    // write request from front to queue
    typedef struct packed {
        logic        valid;
        cesd_entry_t entry;
    } cesd_qwr_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } cesd_qstat_t;

endpackage

[sv/cesd_front.sv]
// ----------------------------------------------------------------------------
// cesd_front
// Accepts raw bytes, tracks escape and number state, and classifies each byte
// into zero, one or two decoded words that are written to the queue.
// ----------------------------------------------------------------------------
module cesd_front
    import cesd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  in_byte,
    input  cesd_qstat_t q_stat,
    output cesd_qwr_t   q_wr
);

    logic       esc_reg;
    logic       esc_next;
    logic [1:0] oct_left_reg;
    logic [1:0] oct_left_next;
    logic [1:0] hex_left_reg;
    logic [1:0] hex_left_next;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;

    logic       accept;
    logic       oct_dig;
    logic       hex_dig;
    logic [3:0] hex_val;
    logic [7:0] cand_a;
    logic [7:0] cand_b;
    logic       a_en;
    logic       b_en;
    logic       a_ok;
    logic       b_ok;

    assign accept = push && !q_stat.full;

    // digit classification
    always_comb
    begin
        oct_dig = in_byte inside {[8'h30:8'h37]};
        hex_dig = (in_byte inside {[8'h30:8'h39]}) || (in_byte inside {[8'h61:8'h66]})
                  || (in_byte inside {[8'h41:8'h46]});
        if (in_byte inside {[8'h30:8'h39]})
        begin
            hex_val = in_byte[3:0];
        end
        else
        begin
            hex_val = in_byte[3:0] + 4'd9;
        end
    end

    // decode of one byte against the current state
    always_comb
    begin
        esc_next      = esc_reg;
        oct_left_next = oct_left_reg;
        hex_left_next = hex_left_reg;
        acc_next      = acc_reg;
        cand_a        = acc_reg;
        cand_b        = in_byte;
        a_en          = 1'b0;
        b_en          = 1'b0;
        if (oct_left_reg != 2'd0)
        begin
            oct_left_next = oct_left_reg - 2'd1;
            if (!oct_dig)
            begin
                oct_left_next = 2'd0;
                a_en          = 1'b1;
                if (in_byte == BACKSLASH)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    b_en = 1'b1;
                end
            end
            else
            begin
                acc_next = {acc_reg[4:0], in_byte[2:0]};
                cand_a   = acc_next;
                a_en     = (oct_left_reg == 2'd1);
            end
        end
        else if (hex_left_reg != 2'd0)
        begin
            hex_left_next = hex_left_reg - 2'd1;
            if (!hex_dig)
            begin
                hex_left_next = 2'd0;
                a_en          = 1'b1;
                if (in_byte == BACKSLASH)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    b_en = 1'b1;
                end
            end
            else
            begin
                acc_next = {acc_reg[3:0], hex_val};
                cand_a   = acc_next;
                a_en     = (hex_left_reg == 2'd1);
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            a_en     = 1'b1;
            case (in_byte)
                LET_A:     cand_a = CH_BEL;
                LET_B:     cand_a = CH_BS;
                LET_F:     cand_a = CH_FF;
                LET_N:     cand_a = CH_LF;
                LET_R:     cand_a = CH_CR;
                LET_T:     cand_a = CH_TAB;
                LET_V:     cand_a = CH_VT;
                CH_SQUOTE: cand_a = CH_SQUOTE;
                BACKSLASH: cand_a = BACKSLASH;
                CH_QMARK:  cand_a = CH_QMARK;
                CH_LF,
                CH_CR:     a_en = 1'b0;
                CH_X:
                begin
                    a_en          = 1'b0;
                    hex_left_next = 2'd2;
                    acc_next      = 8'd0;
                end
                default:
                begin
                    if (oct_dig)
                    begin
                        a_en          = 1'b0;
                        oct_left_next = 2'd2;
                        acc_next      = {5'd0, in_byte[2:0]};
                    end
                    else
                    begin
                        cand_a = in_byte;
                    end
                end
            endcase
        end
        else
        begin
            cand_a = in_byte;
            if (in_byte == BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                a_en = 1'b1;
            end
        end
    end

    // zero bytes are dropped
    assign a_ok = a_en && (cand_a != 8'd0);
    assign b_ok = b_en && (cand_b != 8'd0);

    // queue write
    always_comb
    begin
        q_wr.valid        = accept && (a_ok || b_ok);
        q_wr.entry.two    = a_ok && b_ok;
        q_wr.entry.first  = a_ok ? cand_a : cand_b;
        q_wr.entry.second = cand_b;
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg      <= 1'b0;
            oct_left_reg <= 2'd0;
            hex_left_reg <= 2'd0;
            acc_reg      <= 8'd0;
        end
        else if (accept)
        begin
            esc_reg      <= esc_next;
            oct_left_reg <= oct_left_next;
            hex_left_reg <= hex_left_next;
            acc_reg      <= acc_next;
        end
    end

    // only one kind of number is ever in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        !((oct_left_reg != 2'd0) && (hex_left_reg != 2'd0)))
        else $error("octal and hex digits pending together");

endmodule

[sv/cesd_queue.sv]
// ----------------------------------------------------------------------------
// cesd_queue
// Short queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module cesd_queue
    import cesd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cesd_qwr_t   q_wr,
    input  logic        q_rd,
    output cesd_entry_t q_head,
    output cesd_qstat_t q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cesd_entry_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_head       = mem[rd_ptr_reg];

    assign do_wr = q_wr.valid && !q_stat.full;
    assign do_rd = q_rd && !q_stat.empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= q_wr.entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.valid |-> !q_stat.full)
        else $error("entry written into full queue");

endmodule

[sv/cesd_back.sv]
// ----------------------------------------------------------------------------
// cesd_back
// Takes entries from the queue and delivers their words one per cycle
// via an output register while pop is high, last on each entry's final word.
// ----------------------------------------------------------------------------
module cesd_back
    import cesd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cesd_entry_t q_head,
    input  cesd_qstat_t q_stat,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic        last
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       last_reg;
    logic       last_next;
    logic       sec_valid_reg;
    logic       sec_valid_next;
    logic [7:0] sec_byte_reg;
    logic [7:0] sec_byte_next;
    logic       out_free;

    assign out_free = !out_valid_reg || pop;
    assign q_rd     = out_free && !sec_valid_reg && !q_stat.empty;

    // output register load: held second word first, then next entry
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        sec_valid_next = sec_valid_reg;
        sec_byte_next  = sec_byte_reg;
        if (out_free)
        begin
            if (sec_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = sec_byte_reg;
                last_next      = 1'b1;
                sec_valid_next = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = q_head.first;
                last_next      = !q_head.two;
                sec_valid_next = q_head.two;
                sec_byte_next  = q_head.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    // word payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        sec_byte_reg <= sec_byte_next;
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last     = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sec_valid_reg |-> (out_valid_reg && !last_reg))
        else $error("second word held without its first word on output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_byte_reg != 8'd0))
        else $error("zero word on output");

endmodule

[sv/c_escape_sequence_decoder_unit.sv]
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_unit
// Decoder of C-style backslash escapes on a byte stream.
// ----------------------------------------------------------------------------
// Input channel: in_byte is taken at a rising edge with push high and full
// low. Result channel: while empty is low, out_byte and last show the oldest
// waiting word; it is taken at a rising edge with pop high and empty low.
// Each input byte yields zero, one or two words; last marks the final word
// of one input byte. Zero bytes are never delivered.
// A byte is decoded into a queue entry whose words then pass into the
// output register. Input: one byte per cycle while full is low. Output:
// one word per cycle while pop is high, two-word bytes in order. The front
// decoder and the output stage are parted by a queue of QUEUE_DEPTH entries,
// and full rises only when that queue is full.
// Reset clears the escape and number state, empties the queue and the output
// register. A stalled receiver holds the current word; input goes on being
// taken until the queue fills. Digits pending at the end of a stream stay
// pending until a later byte ends the number.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_unit
    import cesd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       last
);

    cesd_qwr_t   q_wr;
    cesd_qstat_t q_stat;
    cesd_entry_t q_head;
    logic        q_rd;

    assign full = q_stat.full;

    // decode front
    cesd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_byte (in_byte),
        .q_stat  (q_stat),
        .q_wr    (q_wr)
    );

    // entry queue
    cesd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_rd   (q_rd),
        .q_head (q_head),
        .q_stat (q_stat)
    );

    // word delivery back
    cesd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule
